### design/iol_pkg.sv
// Shared types, codes and defaults of the indexed ordered list.
`timescale 1ns / 1ps

package iol_pkg;

    // Default sizes of the list storage.
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Request codes carried in the action field.
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_INSERT     = 3'd4;
    localparam logic [2:0] ACT_REMOVE     = 3'd5;
    localparam logic [2:0] ACT_FIND       = 3'd6;
    localparam logic [2:0] ACT_QUERY      = 3'd7;

    // Status codes returned with every result item.
    localparam logic [2:0] STS_DONE      = 3'd0;
    localparam logic [2:0] STS_EMPTY     = 3'd1;
    localparam logic [2:0] STS_RANGE     = 3'd2;
    localparam logic [2:0] STS_FULL      = 3'd3;
    localparam logic [2:0] STS_NOT_FOUND = 3'd4;

    // One result item as handed from the sequencer to the output stage.
    typedef struct packed {
        logic [31:0] back_value;
        logic [31:0] front_value;
        logic        is_empty;
        logic [6:0]  entry_count;
        logic [6:0]  found_position;
        logic [2:0]  status;
    } iol_result_t;

endpackage

### design/iol_mem.sv
// Entry storage of the list: one write port and one registered read port.
`timescale 1ns / 1ps

module iol_mem #(
    parameter int DEPTH      = iol_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = iol_pkg::DATA_WIDTH_DEF,
    parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output logic [DATA_WIDTH-1:0] rdata,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [DATA_WIDTH-1:0] wdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; rdata updates only while re is high.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/iol_seq.sv
// Request sequencer: decodes an item, shifts or scans the entries, reads front and back.
`timescale 1ns / 1ps

module iol_seq #(
    parameter int DEPTH      = iol_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = iol_pkg::DATA_WIDTH_DEF,
    parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Request side
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            in_action,
    input  logic [5:0]            in_position,
    input  logic [31:0]           in_value,
    // Result side
    output logic                  res_valid,
    input  logic                  res_ready,
    output iol_pkg::iol_result_t  res,
    // Memory port
    output logic                  mem_re,
    output logic [AW-1:0]         mem_raddr,
    input  logic [DATA_WIDTH-1:0] mem_rdata,
    output logic                  mem_we,
    output logic [AW-1:0]         mem_waddr,
    output logic [DATA_WIDTH-1:0] mem_wdata
);

    import iol_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 6) ? CW : 6;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_SHIFT     = 8'b0000_0010,
        ST_PUT       = 8'b0000_0100,
        ST_FIND      = 8'b0000_1000,
        ST_RD_FRONT  = 8'b0001_0000,
        ST_RD_BACK   = 8'b0010_0000,
        ST_WAIT_BACK = 8'b0100_0000,
        ST_OUT       = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         left_reg, left_next;
    logic                  pend_reg, pend_next;
    logic                  up_reg, up_next;
    logic [AW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]         lag_reg, lag_next;
    logic [AW-1:0]         put_addr_reg, put_addr_next;
    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [2:0]            status_reg, status_next;
    logic [6:0]            found_reg, found_next;
    logic [31:0]           front_reg, front_next;
    logic [31:0]           back_reg, back_next;

    logic [PW-1:0]         pos_ext;
    logic [PW-1:0]         cnt_ext;
    logic [CW-1:0]         ins_pos;
    logic                  is_full;
    logic                  is_zero;
    logic                  match;

    // Request decode helpers.
    assign pos_ext = PW'(in_position);
    assign cnt_ext = PW'(cnt_reg);
    assign ins_pos = (pos_ext > cnt_ext) ? cnt_reg : CW'(pos_ext);
    assign is_full = (cnt_reg == CW'(DEPTH));
    assign is_zero = (cnt_reg == '0);
    assign match   = pend_reg && (mem_rdata == data_reg);

    // Next-state and memory access logic.
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        left_next     = left_reg;
        pend_next     = pend_reg;
        up_next       = up_reg;
        rd_ptr_next   = rd_ptr_reg;
        lag_next      = lag_reg;
        put_addr_next = put_addr_reg;
        data_next     = data_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        front_next    = front_reg;
        back_next     = back_reg;
        mem_re        = 1'b0;
        mem_raddr     = rd_ptr_reg;
        mem_we        = 1'b0;
        mem_waddr     = lag_reg;
        mem_wdata     = mem_rdata;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    data_next   = DATA_WIDTH'(in_value);
                    found_next  = '0;
                    status_next = STS_DONE;
                    pend_next   = 1'b0;
                    state_next  = ST_RD_FRONT;
                    unique case (in_action) inside
                        ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT: begin
                            if (is_full) begin
                                status_next = STS_FULL;
                            end else begin
                                // Open a hole at the target by moving the tail up.
                                up_next     = 1'b1;
                                rd_ptr_next = AW'(cnt_reg - CW'(1));
                                state_next  = ST_SHIFT;
                                if (in_action == ACT_PUSH_FRONT) begin
                                    put_addr_next = '0;
                                    left_next     = cnt_reg;
                                end else if (in_action == ACT_PUSH_BACK) begin
                                    put_addr_next = AW'(cnt_reg);
                                    left_next     = '0;
                                end else begin
                                    put_addr_next = AW'(ins_pos);
                                    left_next     = cnt_reg - ins_pos;
                                end
                            end
                        end
                        ACT_POP_FRONT: begin
                            if (is_zero) begin
                                status_next = STS_EMPTY;
                            end else begin
                                up_next     = 1'b0;
                                rd_ptr_next = AW'(1);
                                left_next   = cnt_reg - CW'(1);
                                state_next  = ST_SHIFT;
                            end
                        end
                        ACT_REMOVE: begin
                            if (pos_ext >= cnt_ext) begin
                                status_next = STS_RANGE;
                            end else begin
                                // Close the gap by moving the tail down.
                                up_next     = 1'b0;
                                rd_ptr_next = AW'(pos_ext + PW'(1));
                                left_next   = CW'(cnt_ext - pos_ext - PW'(1));
                                state_next  = ST_SHIFT;
                            end
                        end
                        ACT_POP_BACK: begin
                            if (is_zero) begin
                                status_next = STS_EMPTY;
                            end else begin
                                cnt_next = cnt_reg - CW'(1);
                            end
                        end
                        ACT_FIND: begin
                            rd_ptr_next = '0;
                            left_next   = cnt_reg;
                            status_next = STS_NOT_FOUND;
                            found_next  = 7'(cnt_reg);
                            state_next  = ST_FIND;
                        end
                        ACT_QUERY: begin
                            state_next = ST_RD_FRONT;
                        end
                    endcase
                end
            end

            ST_SHIFT: begin
                // Read one entry per cycle and write it one place over in the following cycle.
                if (left_reg != '0) begin
                    mem_re      = 1'b1;
                    rd_ptr_next = up_reg ? rd_ptr_reg - AW'(1) : rd_ptr_reg + AW'(1);
                    lag_next    = up_reg ? rd_ptr_reg + AW'(1) : rd_ptr_reg - AW'(1);
                    left_next   = left_reg - CW'(1);
                    pend_next   = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    mem_we = 1'b1;
                end
                if (left_reg == '0 && !pend_reg) begin
                    if (up_reg) begin
                        state_next = ST_PUT;
                    end else begin
                        cnt_next   = cnt_reg - CW'(1);
                        state_next = ST_RD_FRONT;
                    end
                end
            end

            ST_PUT: begin
                mem_we     = 1'b1;
                mem_waddr  = put_addr_reg;
                mem_wdata  = data_reg;
                cnt_next   = cnt_reg + CW'(1);
                state_next = ST_RD_FRONT;
            end

            ST_FIND: begin
                // Scan from the front, comparing each entry in the cycle after its read.
                if (left_reg != '0) begin
                    mem_re      = 1'b1;
                    rd_ptr_next = rd_ptr_reg + AW'(1);
                    lag_next    = rd_ptr_reg;
                    left_next   = left_reg - CW'(1);
                end
                pend_next = (left_reg != '0);
                if (match) begin
                    status_next = STS_DONE;
                    found_next  = 7'(lag_reg);
                    pend_next   = 1'b0;
                    left_next   = '0;
                    state_next  = ST_RD_FRONT;
                end else if (left_reg == '0 && !pend_reg) begin
                    state_next = ST_RD_FRONT;
                end
            end

            ST_RD_FRONT: begin
                if (is_zero) begin
                    front_next = '0;
                    back_next  = '0;
                    state_next = ST_OUT;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = '0;
                    state_next = ST_RD_BACK;
                end
            end

            ST_RD_BACK: begin
                front_next = 32'(mem_rdata);
                mem_re     = 1'b1;
                mem_raddr  = AW'(cnt_reg - CW'(1));
                state_next = ST_WAIT_BACK;
            end

            ST_WAIT_BACK: begin
                back_next  = 32'(mem_rdata);
                state_next = ST_OUT;
            end

            ST_OUT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            left_reg  <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            left_reg  <= left_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        up_reg       <= up_next;
        rd_ptr_reg   <= rd_ptr_next;
        lag_reg      <= lag_next;
        put_addr_reg <= put_addr_next;
        data_reg     <= data_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        front_reg    <= front_next;
        back_reg     <= back_next;
    end

    // Handshake and result assembly.
    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);

    always_comb begin
        res.status         = status_reg;
        res.found_position = found_reg;
        res.entry_count    = 7'(cnt_reg);
        res.is_empty       = is_zero;
        res.front_value    = front_reg;
        res.back_value     = back_reg;
    end

    // The count never exceeds the storage depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    // Writes land at or below the current count.
    a_write_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (CW'(mem_waddr) <= cnt_reg))
        else $error("write beyond the list end");

    // A shift never reads the entry it writes in the same cycle.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write collide on one entry");

    // Only one request is in work at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while busy");

endmodule

### design/indexed_ordered_list_core.sv
// Top level of the indexed ordered list: request channel, sequencer, storage and output stage.
`timescale 1ns / 1ps

// Indexed ordered list. Each item on the s_ channel is one request (push or pop
// at either end, insert or remove at a position, find a value, or query), and
// each request yields exactly one result item on the m_ channel with a status,
// the find position, the entry count, an empty flag and the front and back values.
// One request is in work at a time; s_tready is high only while the sequencer
// is idle. Push, insert, pop front and remove move the entries from the target
// on by one place, and find scans from the front until a match; each request
// then reads the front and back values unless the list is empty. The entry
// memory has one read and one write port, and the sequencer moves or compares
// one entry per cycle. s_tready rises again in the cycle after the result moves
// to the output stage. A registered output stage holds the result, so the next
// request is accepted while a result waits; if the receiver still stalls when the
// next result is finished, the sequencer holds it until the output stage frees up.
// Reset (aresetn low, synchronous) empties the list and drops any pending result.
module indexed_ordered_list_core #(
    parameter int DEPTH      = iol_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = iol_pkg::DATA_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [5:0] position, [37:6] value, [39:38] zero
    input  logic [2:0]  s_tuser,   // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // [2:0] status, [9:3] found_position,
                                   // [16:10] entry_count, [17] is_empty,
                                   // [49:18] front_value, [81:50] back_value,
                                   // [87:82] zero
);

    import iol_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;

    logic                  res_valid;
    logic                  res_ready;
    iol_result_t           res;

    logic                  m_valid_reg, m_valid_next;
    iol_result_t           m_res_reg;
    logic                  load;

    iol_seq #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (s_tuser),
        .in_position (s_tdata[5:0]),
        .in_value    (s_tdata[37:6]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata)
    );

    iol_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_mem (
        .aclk  (aclk),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata)
    );

    // Output stage: takes a result whenever it is empty or being drained.
    assign res_ready    = !m_valid_reg || m_tready;
    assign load         = res_valid && res_ready;
    assign m_valid_next = load || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_res_reg.back_value, m_res_reg.front_value,
                       m_res_reg.is_empty, m_res_reg.entry_count,
                       m_res_reg.found_position, m_res_reg.status};

endmodule
